>>> rtl/core/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared constants, types and codes for the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int KEY_COUNT  = 4;
  localparam int KEY_IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int LEVEL_BITS = 4;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CODE_W     = 8;
  localparam int CNT_W      = 8;

  localparam logic [CODE_W-1:0] CODE_NONE        = 8'h00;
  localparam logic [CODE_W-1:0] CODE_SINGLE_BASE = 8'h01;
  localparam logic [CODE_W-1:0] CODE_DOUBLE_BASE = 8'h51;
  localparam logic [CODE_W-1:0] CODE_LONG_BASE   = 8'h81;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [CFG_W-1:0] DC_WINDOW_RST  = 16'd300;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_DC_WINDOW  = 2'd1,
    CFG_LONG_PRESS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_click_window_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } key_res_t;

endpackage

>>> rtl/core/kcc_if.sv
// ----------------------------------------------------------------------------
// kcc_in_if / kcc_out_if
// Valid/ready channels carrying scan words and result words.
// ----------------------------------------------------------------------------
interface kcc_in_if;
  logic                                valid;
  logic                                ready;
  logic [kcc_pkg::TIME_W-1:0]          now_ms;
  logic [kcc_pkg::LEVEL_BITS-1:0]      key_levels;

  modport source (output valid, output now_ms, output key_levels, input ready);
  modport sink   (input valid, input now_ms, input key_levels, output ready);
endinterface

interface kcc_out_if;
  logic                                valid;
  logic                                ready;
  logic [kcc_pkg::CODE_W-1:0]          key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

>>> rtl/core/kcc_key.sv
// ----------------------------------------------------------------------------
// kcc_key
// Per-key debounce and click machine: released, confirm, short, long press.
// ----------------------------------------------------------------------------
module kcc_key (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic [kcc_pkg::KEY_IDX_W-1:0]  key_idx,
  input  logic                           level,
  input  logic [kcc_pkg::TIME_W-1:0]     now_ms,
  input  kcc_pkg::cfg_t                  cfg,
  output kcc_pkg::key_res_t              res
);

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_CONFIRM  = 2'd1,
    PH_SHORT    = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [kcc_pkg::CNT_W-1:0]     count_r, count_nxt, count_inc;
  logic [kcc_pkg::TIME_W-1:0]    press_r, release_r;
  logic                          press_we, release_we;
  logic [kcc_pkg::TIME_W-1:0]    since_press, since_release;
  logic                          deb_over, long_over, window_over;
  logic [kcc_pkg::CODE_W-1:0]    idx_ext;

  assign since_press   = now_ms - press_r;
  assign since_release = now_ms - release_r;
  assign deb_over    = since_press > {{(kcc_pkg::TIME_W-kcc_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
  assign long_over   = since_press > {{(kcc_pkg::TIME_W-kcc_pkg::CFG_W){1'b0}},
                                      cfg.long_press_ms};
  assign window_over = since_release > {{(kcc_pkg::TIME_W-kcc_pkg::CFG_W){1'b0}},
                                        cfg.double_click_window_ms};
  assign count_inc   = count_r + 1'b1;
  assign idx_ext     = kcc_pkg::CODE_W'(key_idx);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    press_we   = 1'b0;
    release_we = 1'b0;
    res.hit    = 1'b0;
    res.code   = kcc_pkg::CODE_NONE;
    case (phase_r)
      PH_RELEASED: begin
        if (!level) begin
          phase_nxt = PH_CONFIRM;
          press_we  = 1'b1;
        end else if (count_r != '0 && window_over) begin
          // late or lone release: report the single click
          count_nxt = '0;
          res.hit   = 1'b1;
          res.code  = kcc_pkg::CODE_SINGLE_BASE + idx_ext;
        end
      end
      PH_CONFIRM: begin
        if (!level) begin
          if (deb_over) phase_nxt = PH_SHORT;
        end else begin
          phase_nxt = PH_RELEASED;
        end
      end
      PH_SHORT: begin
        if (level) begin
          phase_nxt = PH_RELEASED;
          count_nxt = count_inc;
          if (count_inc == kcc_pkg::CNT_W'(1)) begin
            release_we = 1'b1;
          end else if (!window_over) begin
            count_nxt = '0;
            res.hit   = 1'b1;
            res.code  = kcc_pkg::CODE_DOUBLE_BASE + idx_ext;
          end
        end else if (long_over) begin
          phase_nxt = PH_LONG;
        end
      end
      PH_LONG: begin
        if (level) begin
          phase_nxt = PH_RELEASED;
          res.hit   = 1'b1;
          res.code  = kcc_pkg::CODE_LONG_BASE + idx_ext;
        end
      end
      default: begin
        phase_nxt = PH_RELEASED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      count_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // time stamps are only read after they have been written
  always_ff @(posedge clk) begin
    if (step_en && press_we)   press_r   <= now_ms;
    if (step_en && release_we) release_r <= now_ms;
  end

endmodule

>>> rtl/core/key_click_classifier.sv
// ----------------------------------------------------------------------------
// key_click_classifier
// Debounces KEY_COUNT active-low keys and classifies single, double and long
// presses from periodic scan words.
// ----------------------------------------------------------------------------
// Each scan word (now_ms, key_levels) yields exactly one result word, key_code:
// 0 for no event, 1+i for a single click of key i, 0x51+i for a double click
// and 0x81+i for a long press. Keys are examined in index order and the first
// one that reports ends the scan; keys after it keep their state untouched for
// that scan. A scan word is held in the input register and then passes
// through the per-key machines and the priority chain into the result
// register, where its result word is held until it is taken. A new scan word
// is accepted every cycle as long as results are taken; the rate is set by the
// single update of the per-key state, which is read and written in the same
// cycle. Elapsed times are 32-bit wrapping differences. Configuration
// registers (debounce, double click window, long press) are written through
// cfg_we/cfg_index/cfg_wdata and take effect for scans processed after the
// write; write only while idle.
// ----------------------------------------------------------------------------
module key_click_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  kcc_in_if.sink                        in_ch,
  kcc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcc_pkg::CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  kcc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms            <= kcc_pkg::DEBOUNCE_RST;
      cfg_r.double_click_window_ms <= kcc_pkg::DC_WINDOW_RST;
      cfg_r.long_press_ms          <= kcc_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (kcc_pkg::cfg_idx_t'(cfg_index))
        kcc_pkg::CFG_DEBOUNCE:   cfg_r.debounce_ms            <= cfg_wdata;
        kcc_pkg::CFG_DC_WINDOW:  cfg_r.double_click_window_ms <= cfg_wdata;
        kcc_pkg::CFG_LONG_PRESS: cfg_r.long_press_ms          <= cfg_wdata;
        default: begin
          // index beyond the register list: drop the write
        end
      endcase
    end
  end

  // input register stage
  logic                               in_valid_r;
  logic [kcc_pkg::TIME_W-1:0]         now_r;
  logic [kcc_pkg::LEVEL_BITS-1:0]     levels_r;

  // result register stage
  logic                               out_valid_r;
  logic [kcc_pkg::CODE_W-1:0]         code_r;

  logic advance;     // result register can take a new word
  logic fire;        // a held scan word is processed this cycle
  logic in_take;

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // payload holds until the next accepted word
  always_ff @(posedge clk) begin
    if (in_take) begin
      now_r    <= in_ch.now_ms;
      levels_r <= in_ch.key_levels;
    end
  end

  // per-key machines; keys without an input bit read as released
  logic [kcc_pkg::KEY_COUNT-1:0] key_level;
  logic [kcc_pkg::KEY_COUNT-1:0] step_en;
  kcc_pkg::key_res_t             key_res [kcc_pkg::KEY_COUNT];

  for (genvar k = 0; k < kcc_pkg::KEY_COUNT; k++) begin : g_key
    if (k < kcc_pkg::LEVEL_BITS) begin : g_lvl
      assign key_level[k] = levels_r[k];
    end else begin : g_hi
      assign key_level[k] = 1'b1;
    end

    kcc_key u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .step_en (step_en[k]),
      .key_idx (kcc_pkg::KEY_IDX_W'(k)),
      .level   (key_level[k]),
      .now_ms  (now_r),
      .cfg     (cfg_r),
      .res     (key_res[k])
    );
  end

  // priority chain: the first reporting key ends the scan, later keys hold
  logic [kcc_pkg::CODE_W-1:0] scan_code;

  always_comb begin
    logic blocked;
    blocked   = 1'b0;
    scan_code = kcc_pkg::CODE_NONE;
    for (int k = 0; k < kcc_pkg::KEY_COUNT; k++) begin
      step_en[k] = fire && !blocked;
      if (!blocked && key_res[k].hit) begin
        scan_code = key_res[k].code;
        blocked   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      code_r <= scan_code;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_code = code_r;

endmodule

>>> rtl/core/kcc_checker.sv
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks for the key click classifier, bound to the top level.
// ----------------------------------------------------------------------------
module kcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [kcc_pkg::CODE_W-1:0] key_code
);

  localparam logic [kcc_pkg::CODE_W-1:0] KEY_N = kcc_pkg::CODE_W'(kcc_pkg::KEY_COUNT);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(key_code))
    else $error("result word changed while stalled");

  // input backpressure only comes from a full, stalled result stage
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // every result is none or a code of an existing key
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> key_code == kcc_pkg::CODE_NONE
      || (key_code >= kcc_pkg::CODE_SINGLE_BASE
          && key_code < kcc_pkg::CODE_SINGLE_BASE + KEY_N)
      || (key_code >= kcc_pkg::CODE_DOUBLE_BASE
          && key_code < kcc_pkg::CODE_DOUBLE_BASE + KEY_N)
      || (key_code >= kcc_pkg::CODE_LONG_BASE
          && key_code < kcc_pkg::CODE_LONG_BASE + KEY_N))
    else $error("illegal key code");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key_code  (out_ch.key_code)
);
